// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a same-cycle implication on every clock outside reset.
`define GLS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gls assertion failed");

// Check an implication that must hold in the following cycle.
`define GLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gls assertion failed");

`endif

// ===== hdl/gls_pkg.sv =====
`default_nettype none
package gls_pkg;

  localparam int TIME_W    = 64;
  localparam int SIZE_W    = 16;
  localparam int WORK_W    = 32;
  localparam int GAP_W     = 32;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int PROD_W    = TIME_W + SIZE_W;

  localparam logic [6:0] PERCENT = 7'd100;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_TASK   = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSLOT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOSPAN  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP   = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              zero_size;
    logic [SIZE_W-1:0] psize;
    logic [WORK_W-1:0] work;
  } item_t;

endpackage
`default_nettype wire

// ===== hdl/gls_front.sv =====
`default_nettype none
module gls_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire [gls_pkg::OP_W-1:0]   in_operation,
  input  wire [gls_pkg::SIZE_W-1:0] in_partition_size,
  input  wire [gls_pkg::WORK_W-1:0] in_work_amount,
  output logic                      busy,
  output logic                      q_valid,
  output gls_pkg::item_t            q_item,
  input  wire                       q_pop
);
  import gls_pkg::*;

  item_t             qmem [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPTR_W:0]   qcnt_r, qcnt_nxt;
  logic              push, pop;
  item_t             new_item;

  assign busy    = (qcnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (qcnt_r != '0);
  assign q_item  = qmem[rp_r];
  assign push    = start && !busy;
  assign pop     = q_pop && q_valid;

  always_comb begin
    new_item.op        = in_operation;
    new_item.zero_size = (in_partition_size == '0);
    new_item.psize     = in_partition_size;
    new_item.work      = in_work_amount;
  end

  always_comb begin
    wp_nxt   = push ? wp_r + 1'b1 : wp_r;
    rp_nxt   = pop ? rp_r + 1'b1 : rp_r;
    qcnt_nxt = qcnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      qcnt_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      qcnt_r <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wp_r] <= new_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gls_div.sv =====
`default_nettype none
module gls_div #(
  parameter int DVD_W = 48
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       go,
  input  wire [DVD_W-1:0]           dividend,
  input  wire [gls_pkg::SIZE_W-1:0] divisor,
  output logic                      done,
  output logic [DVD_W-1:0]          quotient
);
  import gls_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dq_r, dq_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt, done_r, done_nxt;
  logic [SIZE_W:0]   trial;
  logic              ge;

  assign done     = done_r;
  assign quotient = dq_r;

  always_comb begin
    trial    = {rem_r, dq_r[DVD_W-1]};
    ge       = (trial >= {1'b0, dvs_r});
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      dq_nxt  = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift one dividend bit in, restore when the trial goes negative
      rem_nxt = ge ? SIZE_W'(trial - {1'b0, dvs_r}) : trial[SIZE_W-1:0];
      dq_nxt  = {dq_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/gls_back.sv =====
`default_nettype none
module gls_back #(
  parameter int MAX_SLOTS = 64,
  parameter int FRAC_BITS = 16,
  parameter int IW        = 6,
  parameter int CW        = 7,
  parameter int USAGE_W   = 23
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           q_valid,
  input  gls_pkg::item_t                q_item,
  output logic                          q_pop,
  input  wire                           cfg_we,
  input  wire [gls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [gls_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          out_strobe,
  output logic [gls_pkg::STATUS_W-1:0]  out_status,
  output logic [gls_pkg::TIME_W-1:0]    out_start_time,
  output logic [IW-1:0]                 out_slot_index,
  output logic [gls_pkg::SIZE_W-1:0]    out_assigned_size,
  output logic [gls_pkg::TIME_W-1:0]    out_makespan,
  output logic [USAGE_W-1:0]            out_usage_percent,
  output logic [CW-1:0]                 out_slots_in_use
);
  import gls_pkg::*;

  localparam int DVD_W = WORK_W + FRAC_BITS;
  localparam int NUM_W = PROD_W + CW + 1;
  localparam int DW    = NUM_W + USAGE_W;
  localparam int UCW   = $clog2(USAGE_W + 1);
  localparam int CMPW  = SIZE_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVP = 4'd1;
  localparam logic [3:0] S_APP  = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_DIVT = 4'd4;
  localparam logic [3:0] S_WRB  = 4'd5;
  localparam logic [3:0] S_MULR = 4'd6;
  localparam logic [3:0] S_MULT = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_UDIV = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [SIZE_W-1:0] psize_r, psize_nxt;
  logic [WORK_W-1:0] work_r, work_nxt;
  logic [SIZE_W-1:0] total_r, total_nxt, remain_r, remain_nxt;
  logic [GAP_W-1:0]  gap_r, gap_nxt;
  logic [CW-1:0]     count_r, count_nxt, tasks_r, tasks_nxt, fit_r, fit_nxt;
  logic              full_r, full_nxt;
  logic [CW-1:0]     iss_r, iss_nxt, end_r, end_nxt;
  logic              s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  logic [IW-1:0]     s1_idx_r, s1_idx_nxt;
  logic              have_r, have_nxt;
  logic [TIME_W-1:0] best_fin_r, best_fin_nxt, mk_r, mk_nxt, dur_r, dur_nxt;
  logic [SIZE_W-1:0] best_size_r, best_size_nxt;
  logic [IW-1:0]     pick_r, pick_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;
  logic [PROD_W-1:0] p_r, p_nxt;
  logic [DW-1:0]     rem_r, rem_nxt, ds_r, ds_nxt;
  logic [USAGE_W-1:0] q_r, q_nxt;
  logic [UCW-1:0]    ucnt_r, ucnt_nxt;

  logic              out_strobe_r, out_strobe_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [TIME_W-1:0] out_start_r, out_start_nxt, out_mk_r, out_mk_nxt;
  logic [IW-1:0]     out_idx_r, out_idx_nxt;
  logic [SIZE_W-1:0] out_size_r, out_size_nxt;
  logic [USAGE_W-1:0] out_usage_r, out_usage_nxt;
  logic [CW-1:0]     out_used_r, out_used_nxt;

  // emit request built by the states
  logic              emit, clear;
  logic [STATUS_W-1:0] e_status;
  logic [TIME_W-1:0] e_start, e_mk;
  logic [IW-1:0]     e_idx;
  logic [SIZE_W-1:0] e_size;
  logic [USAGE_W-1:0] e_usage;

  logic [SIZE_W-1:0] size_mem [MAX_SLOTS];
  logic [TIME_W-1:0] fin_mem  [MAX_SLOTS];
  logic [SIZE_W-1:0] rd_size_r;
  logic [TIME_W-1:0] rd_fin_r;
  logic [IW-1:0]     rd_addr, wr_addr;
  logic              we_size, we_fin;
  logic [TIME_W-1:0] wr_fin;

  logic              div_go, div_done;
  logic [DVD_W-1:0]  div_dvd, div_quo;
  logic [SIZE_W-1:0] div_dvs;

  logic [CMPW-1:0]   times_w, room_w;
  logic [TIME_W:0]   fin_sum;
  logic [DW-1:0]     scaled;
  logic [USAGE_W-1:0] k_full;

  gls_div #(.DVD_W(DVD_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_start_time    = out_start_r;
  assign out_slot_index    = out_idx_r;
  assign out_assigned_size = out_size_r;
  assign out_makespan      = out_mk_r;
  assign out_usage_percent = out_usage_r;
  assign out_slots_in_use  = out_used_r;

  assign q_pop   = (state_r == S_IDLE) && q_valid;
  assign rd_addr = iss_r[IW-1:0];
  assign k_full  = USAGE_W'(PERCENT) << FRAC_BITS;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    psize_nxt     = psize_r;
    work_nxt      = work_r;
    total_nxt     = total_r;
    gap_nxt       = gap_r;
    remain_nxt    = remain_r;
    count_nxt     = count_r;
    tasks_nxt     = tasks_r;
    fit_nxt       = fit_r;
    full_nxt      = full_r;
    iss_nxt       = iss_r;
    end_nxt       = end_r;
    s1_v_nxt      = 1'b0;
    s1_idx_nxt    = s1_idx_r;
    s2_v_nxt      = 1'b0;
    have_nxt      = have_r;
    best_fin_nxt  = best_fin_r;
    best_size_nxt = best_size_r;
    pick_nxt      = pick_r;
    mk_nxt        = mk_r;
    dur_nxt       = dur_r;
    acc_nxt       = acc_r;
    p_nxt         = p_r;
    rem_nxt       = rem_r;
    ds_nxt        = ds_r;
    q_nxt         = q_r;
    ucnt_nxt      = ucnt_r;
    div_go        = 1'b0;
    div_dvd       = DVD_W'(remain_r);
    div_dvs       = psize_r;
    we_size       = 1'b0;
    we_fin        = 1'b0;
    wr_addr       = count_r[IW-1:0];
    wr_fin        = '0;
    emit          = 1'b0;
    clear         = 1'b0;
    e_status      = ST_OK;
    e_start       = '0;
    e_mk          = '0;
    e_idx         = '0;
    e_size        = '0;
    e_usage       = '0;
    times_w       = CMPW'(div_quo[SIZE_W-1:0]);
    room_w        = CMPW'(MAX_SLOTS) - CMPW'(count_r);
    fin_sum       = {1'b0, best_fin_r} + {1'b0, dur_r};
    scaled        = ((DW'(acc_r) << 6) + (DW'(acc_r) << 5) + (DW'(acc_r) << 2))
                    << FRAC_BITS;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          op_nxt    = q_item.op;
          psize_nxt = q_item.psize;
          work_nxt  = q_item.work;
          unique case (q_item.op)
            OP_ADD: begin
              if (q_item.zero_size) begin
                emit     = 1'b1;
                e_status = ST_ZERO;
              end else begin
                div_go    = 1'b1;
                div_dvd   = DVD_W'(remain_r);
                div_dvs   = q_item.psize;
                state_nxt = S_DIVP;
              end
            end
            OP_TASK: begin
              if (count_r == '0) begin
                emit     = 1'b1;
                e_status = ST_NOSLOT;
              end else begin
                have_nxt = 1'b0;
                // first pass over the table: take the next untouched slot
                if (tasks_r < count_r) begin
                  iss_nxt   = tasks_r;
                  end_nxt   = tasks_r + 1'b1;
                  tasks_nxt = tasks_r + 1'b1;
                end else begin
                  iss_nxt = '0;
                  end_nxt = count_r;
                end
                state_nxt = S_SCAN;
              end
            end
            OP_FINISH: begin
              if (count_r == '0) begin
                emit     = 1'b1;
                clear    = 1'b1;
                e_status = ST_NOSLOT;
              end else begin
                iss_nxt   = '0;
                end_nxt   = count_r;
                mk_nxt    = '0;
                acc_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_DIVP: begin
        if (div_done) begin
          full_nxt  = (times_w > room_w);
          fit_nxt   = (times_w > room_w) ? CW'(room_w) : CW'(times_w);
          state_nxt = S_APP;
        end
      end
      S_APP: begin
        if (fit_r != '0) begin
          we_size    = 1'b1;
          we_fin     = 1'b1;
          wr_addr    = count_r[IW-1:0];
          wr_fin     = '0;
          count_nxt  = count_r + 1'b1;
          remain_nxt = remain_r - psize_r;
          fit_nxt    = fit_r - 1'b1;
        end else begin
          emit      = 1'b1;
          e_status  = full_r ? ST_FULL : ST_OK;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (iss_r < end_r) begin
          iss_nxt    = iss_r + 1'b1;
          s1_v_nxt   = 1'b1;
          s1_idx_nxt = iss_r[IW-1:0];
        end
        if (s1_v_r) begin
          if (op_r == OP_TASK) begin
            // strict compare keeps the lowest index on ties
            if (!have_r || (rd_fin_r < best_fin_r)) begin
              have_nxt      = 1'b1;
              best_fin_nxt  = rd_fin_r;
              best_size_nxt = rd_size_r;
              pick_nxt      = s1_idx_r;
            end
          end else begin
            if (rd_fin_r > mk_r) begin
              mk_nxt = rd_fin_r;
            end
            p_nxt    = PROD_W'(rd_fin_r) * PROD_W'(rd_size_r);
            s2_v_nxt = 1'b1;
          end
        end
        if (s2_v_r) begin
          acc_nxt = acc_r + NUM_W'(p_r);
        end
        if ((iss_r == end_r) && !s1_v_r && !s2_v_r) begin
          if (op_r == OP_TASK) begin
            div_go    = 1'b1;
            div_dvd   = {work_r, FRAC_BITS'(0)};
            div_dvs   = best_size_r;
            state_nxt = S_DIVT;
          end else if (mk_r == '0) begin
            emit      = 1'b1;
            clear     = 1'b1;
            e_status  = ST_NOSPAN;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_MULR;
          end
        end
      end
      S_DIVT: begin
        if (div_done) begin
          dur_nxt   = TIME_W'(div_quo) + TIME_W'(gap_r);
          state_nxt = S_WRB;
        end
      end
      S_WRB: begin
        we_fin    = 1'b1;
        wr_addr   = pick_r;
        wr_fin    = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
        emit      = 1'b1;
        e_start   = best_fin_r;
        e_idx     = pick_r;
        e_size    = best_size_r;
        state_nxt = S_IDLE;
      end
      S_MULR: begin
        p_nxt     = PROD_W'(mk_r) * PROD_W'(remain_r);
        state_nxt = S_MULT;
      end
      S_MULT: begin
        acc_nxt   = acc_r + NUM_W'(p_r);
        p_nxt     = PROD_W'(mk_r) * PROD_W'(total_r);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (acc_r >= NUM_W'(p_r)) begin
          emit      = 1'b1;
          clear     = 1'b1;
          e_mk      = mk_r;
          e_usage   = k_full;
          state_nxt = S_IDLE;
        end else begin
          rem_nxt   = scaled;
          ds_nxt    = DW'(p_r) << (USAGE_W - 1);
          q_nxt     = '0;
          ucnt_nxt  = '0;
          state_nxt = S_UDIV;
        end
      end
      S_UDIV: begin
        if (rem_r >= ds_r) begin
          rem_nxt = rem_r - ds_r;
        end
        q_nxt    = {q_r[USAGE_W-2:0], (rem_r >= ds_r)};
        ds_nxt   = ds_r >> 1;
        ucnt_nxt = ucnt_r + 1'b1;
        if (ucnt_r == UCW'(USAGE_W - 1)) begin
          emit      = 1'b1;
          clear     = 1'b1;
          e_mk      = mk_r;
          e_usage   = {q_r[USAGE_W-2:0], (rem_r >= ds_r)};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (clear) begin
      count_nxt  = '0;
      tasks_nxt  = '0;
      remain_nxt = total_r;
    end

    // configuration is to be written only while idle; the block itself does not enforce this
    if (cfg_we) begin
      if (cfg_index == CFG_TOTAL) begin
        total_nxt  = cfg_data[SIZE_W-1:0];
        remain_nxt = cfg_data[SIZE_W-1:0];
      end else begin
        gap_nxt = cfg_data[GAP_W-1:0];
      end
    end

    out_strobe_nxt = emit;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_mk_nxt     = out_mk_r;
    out_idx_nxt    = out_idx_r;
    out_size_nxt   = out_size_r;
    out_usage_nxt  = out_usage_r;
    out_used_nxt   = out_used_r;
    if (emit) begin
      out_status_nxt = e_status;
      out_start_nxt  = e_start;
      out_mk_nxt     = e_mk;
      out_idx_nxt    = e_idx;
      out_size_nxt   = e_size;
      out_usage_nxt  = e_usage;
      out_used_nxt   = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= SIZE_W'(1);
      remain_r     <= SIZE_W'(1);
      gap_r        <= '0;
      count_r      <= '0;
      tasks_r      <= '0;
      fit_r        <= '0;
      iss_r        <= '0;
      end_r        <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      ucnt_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      remain_r     <= remain_nxt;
      gap_r        <= gap_nxt;
      count_r      <= count_nxt;
      tasks_r      <= tasks_nxt;
      fit_r        <= fit_nxt;
      iss_r        <= iss_nxt;
      end_r        <= end_nxt;
      s1_v_r       <= s1_v_nxt;
      s2_v_r       <= s2_v_nxt;
      ucnt_r       <= ucnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    psize_r     <= psize_nxt;
    work_r      <= work_nxt;
    full_r      <= full_nxt;
    s1_idx_r    <= s1_idx_nxt;
    have_r      <= have_nxt;
    best_fin_r  <= best_fin_nxt;
    best_size_r <= best_size_nxt;
    pick_r      <= pick_nxt;
    mk_r        <= mk_nxt;
    dur_r       <= dur_nxt;
    acc_r       <= acc_nxt;
    p_r         <= p_nxt;
    rem_r       <= rem_nxt;
    ds_r        <= ds_nxt;
    q_r         <= q_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_mk_r     <= out_mk_nxt;
    out_idx_r    <= out_idx_nxt;
    out_size_r   <= out_size_nxt;
    out_usage_r  <= out_usage_nxt;
    out_used_r   <= out_used_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_size) begin
      size_mem[wr_addr] <= psize_r;
    end
    if (we_fin) begin
      fin_mem[wr_addr] <= wr_fin;
    end
    rd_size_r <= size_mem[rd_addr];
    rd_fin_r  <= fin_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/greedy_partition_list_scheduler.sv =====
`default_nettype none
// Greedy partition list scheduler.
// Items enter on start/in_* and are taken when busy is low; a two-entry
// queue sits in front of the execution sequencer, so busy rises only when
// that queue is full. Each item yields one result, shown on the out_* ports
// for a single cycle with out_strobe high; the receiver cannot stall it.
// Configuration (cfg_we/cfg_index/cfg_data) is written while idle:
// index 0 total resource (also reloads the remaining resource), 1 gap time.
// Steps per item:
//   add size: serial divider, then the partitions that fit are appended
//   schedule task: a walk over the whole table when it is revisited, or over
//     the next untouched slot while slots are still being filled, then the serial divider
//   finish: the slot walk, then the bit-serial usage divider, which is
//     skipped at full usage and on a zero makespan;
//     other codes emit their result straight from idle.
// Slot sizes and finish times live in two single-port-read memories; a
// slot walk reads one entry per cycle.
// Reset clears the table (slot count 0), sets total and remaining resource
// to 1 and gap time to 0; no clearing pass is needed.
module greedy_partition_list_scheduler #(
  parameter int MAX_SLOTS = 64,
  parameter int FRAC_BITS = 16,
  localparam int IW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  localparam int CW       = $clog2(MAX_SLOTS + 1),
  localparam int USAGE_W  = FRAC_BITS + 7
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire [gls_pkg::OP_W-1:0]       in_operation,
  input  wire [gls_pkg::SIZE_W-1:0]     in_partition_size,
  input  wire [gls_pkg::WORK_W-1:0]     in_work_amount,
  input  wire                           cfg_we,
  input  wire [gls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [gls_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          out_strobe,
  output logic [gls_pkg::STATUS_W-1:0]  out_status,
  output logic [gls_pkg::TIME_W-1:0]    out_start_time,
  output logic [IW-1:0]                 out_slot_index,
  output logic [gls_pkg::SIZE_W-1:0]    out_assigned_size,
  output logic [gls_pkg::TIME_W-1:0]    out_makespan,
  output logic [USAGE_W-1:0]            out_usage_percent,
  output logic [CW-1:0]                 out_slots_in_use
);
  import gls_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  gls_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_operation      (in_operation),
    .in_partition_size (in_partition_size),
    .in_work_amount    (in_work_amount),
    .busy              (busy),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop)
  );

  gls_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .FRAC_BITS (FRAC_BITS),
    .IW        (IW),
    .CW        (CW),
    .USAGE_W   (USAGE_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_start_time    (out_start_time),
    .out_slot_index    (out_slot_index),
    .out_assigned_size (out_assigned_size),
    .out_makespan      (out_makespan),
    .out_usage_percent (out_usage_percent),
    .out_slots_in_use  (out_slots_in_use)
  );

endmodule
`default_nettype wire

// ===== hdl/gls_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module gls_checker #(
  parameter int MAX_SLOTS = 64,
  parameter int FRAC_BITS = 16,
  parameter int IW        = 6,
  parameter int CW        = 7,
  parameter int USAGE_W   = 23
) (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          start,
  input wire                          busy,
  input wire                          out_strobe,
  input wire [gls_pkg::STATUS_W-1:0]  out_status,
  input wire [gls_pkg::TIME_W-1:0]    out_start_time,
  input wire [IW-1:0]                 out_slot_index,
  input wire [gls_pkg::TIME_W-1:0]    out_makespan,
  input wire [USAGE_W-1:0]            out_usage_percent,
  input wire [CW-1:0]                 out_slots_in_use
);
  import gls_pkg::*;

  // a full table means every slot got filled
  `GLS_ASSERT_NOW(a_full_count, clk, rst_n, out_strobe && (out_status == ST_FULL), out_slots_in_use == CW'(MAX_SLOTS))
  // results with a status other than OK leave no task fields
  `GLS_ASSERT_NOW(a_fail_clean, clk, rst_n, out_strobe && (out_status != ST_OK), (out_start_time == '0) && (out_slot_index == '0))
  // usage never tops one hundred percent
  `GLS_ASSERT_NOW(a_usage_max, clk, rst_n, out_strobe, out_usage_percent <= (USAGE_W'(PERCENT) << FRAC_BITS))
  // a finish clears the table
  `GLS_ASSERT_NOW(a_span_clear, clk, rst_n, out_strobe && (out_makespan != '0), out_slots_in_use == '0)
  // the queue only fills on a transaction
  `GLS_ASSERT_NEXT(a_busy_rise, clk, rst_n, !busy && !start, !busy)

endmodule

bind greedy_partition_list_scheduler gls_checker #(
  .MAX_SLOTS (MAX_SLOTS),
  .FRAC_BITS (FRAC_BITS),
  .IW        (IW),
  .CW        (CW),
  .USAGE_W   (USAGE_W)
) u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_status        (out_status),
  .out_start_time    (out_start_time),
  .out_slot_index    (out_slot_index),
  .out_makespan      (out_makespan),
  .out_usage_percent (out_usage_percent),
  .out_slots_in_use  (out_slots_in_use)
);
`default_nettype wire
